>>> hw/rtl/prat_pkg.sv
// Shared types and constants for the page run allocator with translate.
package prat_pkg;

  // Request word: one allocate, deallocate or translate command.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] request_bytes;
    logic [31:0] backing_base;
    logic [31:0] address;
    logic [12:0] access_length;
    logic        is_exec;
  } req_t;

  // Response word.
  typedef struct packed {
    logic        status;
    logic [31:0] result_address;
  } rsp_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [31:0] region_base;
    logic [31:0] region_limit;
    logic [31:0] max_request_bytes;
  } cfg_t;

  // Shared adder/subtractor request and response.
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [33:0] res;
    logic        borrow;
    logic        zero;
  } alu_rsp_t;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_DEALLOC = 2'd1;
  localparam logic [1:0] KIND_XLATE   = 2'd2;

  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [1:0] REG_REGION_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAX_REQ      = 2'd2;

  localparam logic [31:0] RST_REGION_BASE  = 32'd0;
  localparam logic [31:0] RST_REGION_LIMIT = 32'd1048576;
  localparam logic [31:0] RST_MAX_REQ      = 32'd1048576;

endpackage

>>> hw/rtl/page_run_allocator_with_translate_core.sv
// Page run allocator with translate: sequencer, page table memory and response register.
//
//   channel   direction  handshake                        word
//   req       in         req_valid_i / req_stall_o        req_i  (req_t)
//   rsp       out        rsp_valid_o / rsp_stall_i        rsp_o  (rsp_t)
//   cfg       in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// Every page table read goes through the single registered read port, and all address
// arithmetic goes through the one shared adder. After reset the table is cleared one
// entry a cycle; req stalls then. req stalls whenever an item is in flight; a finished
// word waits in the rsp register while the next req word is taken. PAGE_BYTES must be a
// power of two.
module page_run_allocator_with_translate_core
  import prat_pkg::*;
#(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  req_t              req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output rsp_t              rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W = $clog2(PAGE_COUNT + 1);
  localparam int AW    = $clog2(PAGE_COUNT);
  localparam int PB_W  = $clog2(PAGE_BYTES);

  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] PC_IDX   = IDX_W'(PAGE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAGE_COUNT - 1);
  localparam logic [IDX_W:0]   PC_EXT   = (IDX_W + 1)'(PAGE_COUNT);
  localparam logic [31:0]      PC32     = 32'(PAGE_COUNT);
  localparam logic [33:0]      PC34     = 34'(PAGE_COUNT);
  localparam logic [32:0]      PB33     = 33'(PAGE_BYTES);
  localparam logic [32:0]      PB_M1    = 33'(PAGE_BYTES - 1);
  localparam logic [33:0]      PB34     = 34'(PAGE_BYTES);
  localparam logic [33:0]      TWO32    = 34'h1_0000_0000;

  localparam rsp_t RSP_FAIL = '{status: 1'b1, result_address: 32'd0};
  localparam rsp_t RSP_OK0  = '{status: 1'b0, result_address: 32'd0};

  localparam logic [4:0] ST_CLR    = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_DONE   = 5'd2;
  localparam logic [4:0] ST_A_SIZE = 5'd3;
  localparam logic [4:0] ST_A_NPG  = 5'd4;
  localparam logic [4:0] ST_A_AFT  = 5'd5;
  localparam logic [4:0] ST_A_BEF  = 5'd6;
  localparam logic [4:0] ST_S_TOP  = 5'd7;
  localparam logic [4:0] ST_S_TOPW = 5'd8;
  localparam logic [4:0] ST_S_DN   = 5'd9;
  localparam logic [4:0] ST_S_DNW  = 5'd10;
  localparam logic [4:0] ST_S_LFTW = 5'd11;
  localparam logic [4:0] ST_A_FILL = 5'd12;
  localparam logic [4:0] ST_A_RES  = 5'd13;
  localparam logic [4:0] ST_D_LO   = 5'd14;
  localparam logic [4:0] ST_D_HI   = 5'd15;
  localparam logic [4:0] ST_D_RDW  = 5'd16;
  localparam logic [4:0] ST_D_CLR  = 5'd17;
  localparam logic [4:0] ST_D_CHK  = 5'd18;
  localparam logic [4:0] ST_T_LO   = 5'd19;
  localparam logic [4:0] ST_T_HI   = 5'd20;
  localparam logic [4:0] ST_T_RDW  = 5'd21;
  localparam logic [4:0] ST_T_NXT  = 5'd22;
  localparam logic [4:0] ST_T_NXTW = 5'd23;
  localparam logic [4:0] ST_T_RES  = 5'd24;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [4:0]       state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      tmp_q, tmp_d;
  logic [31:0]      ent_q, ent_d;
  logic [31:0]      aft_q, aft_d;
  logic [31:0]      bef_q, bef_d;
  req_t             req_q, req_d;
  rsp_t             pend_q, pend_d;
  rsp_t             rsp_q;
  logic             rsp_valid_q;
  logic             rsp_load;

  logic [31:0]      page_tbl_q [PAGE_COUNT];
  logic [31:0]      rd_data_q;
  logic             rdz_q;
  logic [IDX_W-1:0] rd_idx;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ent_rd;

  logic [IDX_W:0]   i_plus_n;
  logic [IDX_W-1:0] j_top;
  logic [IDX_W-1:0] i_inc;
  logic [31:0]      pidx;
  logic             pidx_oob;
  logic [33:0]      npg;

  prat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prat_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Index PAGE_COUNT is the guard entry past the table; it always reads empty.
  assign ent_rd   = rdz_q ? 32'd0 : rd_data_q;
  assign i_plus_n = {1'b0, i_q} + {1'b0, n_q};
  assign j_top    = i_plus_n[IDX_W-1:0] + IDX_ONE;
  assign i_inc    = i_q + IDX_ONE;
  assign pidx     = acc_q >> PB_W;
  assign pidx_oob = (pidx >= PC32);
  assign npg      = alu_rsp.res >> PB_W;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    n_d       = n_q;
    first_d   = first_q;
    acc_d     = acc_q;
    tmp_d     = tmp_q;
    ent_d     = ent_q;
    aft_d     = aft_q;
    bef_d     = bef_q;
    req_d     = req_q;
    pend_d    = pend_q;
    alu_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = 32'd0;
    rd_idx    = i_q;

    case (state_q)
      ST_CLR: begin
        ram_we = 1'b1;
        i_d    = i_inc;
        if (i_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          case (req_i.kind)
            KIND_ALLOC:   state_d = ST_A_SIZE;
            KIND_DEALLOC: state_d = ST_D_LO;
            KIND_XLATE:   state_d = ST_T_LO;
            default: begin
              pend_d  = RSP_FAIL;
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      // ---- allocate: checks ----
      ST_A_SIZE: begin
        alu_req = '{a: 33'(cfg.max_request_bytes), b: 33'(req_q.request_bytes), sub: 1'b1};
        if (alu_rsp.borrow || (req_q.backing_base == 32'd0)) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_A_NPG;
        end
      end

      ST_A_NPG: begin
        alu_req = '{a: 33'(req_q.request_bytes), b: PB_M1, sub: 1'b0};
        if (npg >= PC34) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          n_d     = npg[IDX_W-1:0];
          state_d = ST_A_AFT;
        end
      end

      ST_A_AFT: begin
        alu_req = '{a: 33'(req_q.backing_base), b: 33'(n_q) << PB_W, sub: 1'b0};
        if (alu_rsp.res > TWO32) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          aft_d   = alu_rsp.res[31:0];
          state_d = ST_A_BEF;
        end
      end

      ST_A_BEF: begin
        alu_req = '{a: 33'(req_q.backing_base), b: PB33, sub: 1'b1};
        bef_d   = alu_rsp.res[31:0];
        i_d     = '0;
        state_d = ST_S_TOP;
      end

      // ---- allocate: first-fit scan ----
      ST_S_TOP: begin
        if (i_plus_n >= PC_EXT) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          j_d     = j_top;
          rd_idx  = j_top;
          state_d = ST_S_TOPW;
        end
      end

      ST_S_TOPW: begin
        // entry just past the run continuing the new block: skip over it
        alu_req = '{a: 33'(ent_rd), b: 33'(aft_q), sub: 1'b1};
        if ((ent_rd != 32'd0) && alu_rsp.zero) begin
          i_d     = j_q;
          state_d = ST_S_TOP;
        end else begin
          j_d     = j_q - IDX_ONE;
          state_d = ST_S_DN;
        end
      end

      ST_S_DN: begin
        if (j_q > i_q) begin
          rd_idx  = j_q;
          state_d = ST_S_DNW;
        end else begin
          rd_idx  = i_q;
          state_d = ST_S_LFTW;
        end
      end

      ST_S_DNW: begin
        if (ent_rd != 32'd0) begin
          i_d     = j_q;
          state_d = ST_S_TOP;
        end else begin
          j_d     = j_q - IDX_ONE;
          state_d = ST_S_DN;
        end
      end

      ST_S_LFTW: begin
        alu_req = '{a: 33'(ent_rd), b: 33'(bef_q), sub: 1'b1};
        if ((ent_rd != 32'd0) && alu_rsp.zero) begin
          i_d     = i_inc;
          state_d = ST_S_TOP;
        end else begin
          first_d = i_inc;
          i_d     = i_inc;
          j_d     = n_q;
          acc_d   = req_q.backing_base;
          state_d = ST_A_FILL;
        end
      end

      ST_A_FILL: begin
        if (j_q == '0) begin
          state_d = ST_A_RES;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = acc_q;
          alu_req   = '{a: 33'(acc_q), b: PB33, sub: 1'b0};
          acc_d     = alu_rsp.res[31:0];
          i_d       = i_inc;
          j_d       = j_q - IDX_ONE;
        end
      end

      ST_A_RES: begin
        alu_req = '{a: 33'(cfg.region_base), b: 33'(first_q) << PB_W, sub: 1'b0};
        pend_d  = '{status: 1'b0, result_address: alu_rsp.res[31:0]};
        state_d = ST_DONE;
      end

      // ---- deallocate ----
      ST_D_LO: begin
        alu_req = '{a: 33'(req_q.address), b: 33'(cfg.region_base), sub: 1'b1};
        acc_d   = alu_rsp.res[31:0];
        if (alu_rsp.borrow) begin
          pend_d  = RSP_OK0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_D_HI;
        end
      end

      ST_D_HI: begin
        alu_req = '{a: 33'(req_q.address), b: 33'(cfg.region_limit), sub: 1'b1};
        i_d     = pidx[IDX_W-1:0];
        rd_idx  = pidx[IDX_W-1:0];
        if (!alu_rsp.borrow || pidx_oob) begin
          pend_d  = RSP_OK0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_D_RDW;
        end
      end

      ST_D_RDW: begin
        acc_d = ent_rd;
        if (ent_rd == 32'd0) begin
          pend_d  = RSP_OK0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_D_CLR;
        end
      end

      ST_D_CLR: begin
        // clear this page, fetch the next one while the expected address steps
        ram_we  = 1'b1;
        alu_req = '{a: 33'(acc_q), b: PB33, sub: 1'b0};
        acc_d   = alu_rsp.res[31:0];
        i_d     = i_inc;
        rd_idx  = i_inc;
        if (i_inc < PC_IDX) begin
          state_d = ST_D_CHK;
        end else begin
          pend_d  = RSP_OK0;
          state_d = ST_DONE;
        end
      end

      ST_D_CHK: begin
        alu_req = '{a: 33'(ent_rd), b: 33'(acc_q), sub: 1'b1};
        if ((ent_rd != 32'd0) && alu_rsp.zero) begin
          state_d = ST_D_CLR;
        end else begin
          pend_d  = RSP_OK0;
          state_d = ST_DONE;
        end
      end

      // ---- translate ----
      ST_T_LO: begin
        alu_req = '{a: 33'(req_q.address), b: 33'(cfg.region_base), sub: 1'b1};
        acc_d   = alu_rsp.res[31:0];
        if (req_q.is_exec || alu_rsp.borrow) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_T_HI;
        end
      end

      ST_T_HI: begin
        alu_req = '{a: 33'(req_q.address), b: 33'(cfg.region_limit), sub: 1'b1};
        i_d     = pidx[IDX_W-1:0];
        rd_idx  = pidx[IDX_W-1:0];
        if (!alu_rsp.borrow || pidx_oob) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_T_RDW;
        end
      end

      ST_T_RDW: begin
        alu_req = '{a: 33'(acc_q[PB_W-1:0]), b: 33'(req_q.access_length), sub: 1'b0};
        ent_d   = ent_rd;
        if (ent_rd == 32'd0) begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end else if (alu_rsp.res > PB34) begin
          state_d = ST_T_NXT;
        end else begin
          state_d = ST_T_RES;
        end
      end

      ST_T_NXT: begin
        alu_req = '{a: 33'(ent_q), b: PB33, sub: 1'b0};
        tmp_d   = alu_rsp.res[31:0];
        rd_idx  = i_inc;
        state_d = ST_T_NXTW;
      end

      ST_T_NXTW: begin
        alu_req = '{a: 33'(ent_rd), b: 33'(tmp_q), sub: 1'b1};
        if ((ent_rd != 32'd0) && alu_rsp.zero) begin
          state_d = ST_T_RES;
        end else begin
          pend_d  = RSP_FAIL;
          state_d = ST_DONE;
        end
      end

      ST_T_RES: begin
        alu_req = '{a: 33'(ent_q), b: 33'(acc_q[PB_W-1:0]), sub: 1'b0};
        pend_d  = '{status: 1'b0, result_address: alu_rsp.res[31:0]};
        state_d = ST_DONE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    n_q     <= n_d;
    first_q <= first_d;
    acc_q   <= acc_d;
    tmp_q   <= tmp_d;
    ent_q   <= ent_d;
    aft_q   <= aft_d;
    bef_q   <= bef_d;
    req_q   <= req_d;
    pend_q  <= pend_d;
  end

  // page table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      page_tbl_q[ram_waddr] <= ram_wdata;
    end
    rd_data_q <= page_tbl_q[rd_idx[AW-1:0]];
    rdz_q     <= (rd_idx == PC_IDX);
  end

  // response register
  assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= pend_q;
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> req_stall_o)
    else $error("request word taken without going busy");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status) |-> (rsp_o.result_address == 32'd0))
    else $error("failed response carries a nonzero address");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the done state");

  a_fill_not_page0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_FILL && ram_we) |-> (i_q != '0))
    else $error("allocation fill wrote page zero");
`endif

endmodule

>>> hw/rtl/prat_alu.sv
// Shared 33-bit add/subtract unit with borrow and zero flags.
module prat_alu
  import prat_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [33:0] opb;
  logic [33:0] sum;

  assign opb = req_i.sub ? ~{1'b0, req_i.b} : {1'b0, req_i.b};
  assign sum = {1'b0, req_i.a} + opb + {33'd0, req_i.sub};

  assign rsp_o.res    = sum;
  assign rsp_o.borrow = req_i.sub & sum[33];
  assign rsp_o.zero   = (sum == '0);

endmodule

>>> hw/rtl/prat_cfg.sv
// APB-style configuration registers: region base, region limit, size limit.
module prat_cfg
  import prat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_base       <= RST_REGION_BASE;
      cfg_q.region_limit      <= RST_REGION_LIMIT;
      cfg_q.max_request_bytes <= RST_MAX_REQ;
    end else if (wr_en) begin
      case (paddr[CFG_AW-1:2])
        REG_REGION_BASE: begin
          cfg_q.region_base <= pwdata;
        end
        REG_REGION_LIMIT: begin
          cfg_q.region_limit <= pwdata;
        end
        REG_MAX_REQ: begin
          cfg_q.max_request_bytes <= pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_REGION_BASE:  prdata = cfg_q.region_base;
      REG_REGION_LIMIT: prdata = cfg_q.region_limit;
      REG_MAX_REQ:      prdata = cfg_q.max_request_bytes;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> verif/page_run_allocator_with_translate_core_tb.sv
// Testbench for the page run allocator core: random and directed words checked against a predictor.
`timescale 1ns / 100ps

module page_run_allocator_with_translate_core_tb
  import prat_pkg::*;
();
  localparam int PAGE_COUNT = 256;
  localparam int PAGE_BYTES = 4096;
  localparam logic [1:0] KIND_NONE = 2'd3;

  class page_map_scoreboard #(int PAGES = 256, int PAGE_SZ = 4096);
    logic [31:0] page_map [0:PAGES];
    logic [31:0] region_base;
    logic [31:0] region_limit;
    logic [31:0] max_req;
    rsp_t        pending_rsp [$];
    int          errors;

    function new();
      int k;
      for (k = 0; k <= PAGES; k++) page_map[k] = '0;
      region_base  = RST_REGION_BASE;
      region_limit = RST_REGION_LIMIT;
      max_req      = RST_MAX_REQ;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_REGION_BASE:  region_base  = value;
        REG_REGION_LIMIT: region_limit = value;
        REG_MAX_REQ:      max_req      = value;
        default: ;
      endcase
    endfunction

    // an empty entry never continues a run, even where 0 is the backing address wanted
    function bit continues_run(logic [31:0] entry, logic [31:0] want);
      return entry != 0 && entry == want;
    endfunction

    // first-fit search from page 1; 0 means no room
    function int first_fit(int npg, logic [31:0] base);
      logic [31:0] left_want;
      logic [31:0] right_want;
      int i;
      int j;
      int k;
      int nxt;
      left_want  = base - PAGE_SZ;
      right_want = base + 32'(npg) * 32'(PAGE_SZ);
      i = 0;
      while (i < PAGES - npg) begin
        j = i + 1 + npg;
        nxt = 0;
        if (continues_run(page_map[j], right_want)) begin
          nxt = j;
        end else begin
          k = j - 1;
          while (k > i && nxt == 0) begin
            if (page_map[k] != 0) nxt = k;
            k--;
          end
          if (nxt == 0 && continues_run(page_map[i], left_want)) nxt = i + 1;
        end
        if (nxt == 0) return i + 1;
        i = nxt;
      end
      return 0;
    endfunction

    function rsp_t allocate(logic [31:0] bytes, logic [31:0] base);
      rsp_t        r;
      logic [63:0] npg;
      int          first;
      int          k;
      r.status         = 1'b1;
      r.result_address = '0;
      if (bytes > max_req || base == 0) return r;
      npg = ({32'd0, bytes} + 64'(PAGE_SZ) - 64'd1) / 64'(PAGE_SZ);
      if (npg >= 64'(PAGES)) return r;
      if ({32'd0, base} + npg * 64'(PAGE_SZ) > 64'h1_0000_0000) return r;
      first = first_fit(int'(npg), base);
      if (first == 0) return r;
      for (k = 0; k < int'(npg); k++) page_map[first + k] = base + 32'(k) * 32'(PAGE_SZ);
      r.status         = 1'b0;
      r.result_address = region_base + 32'(first) * 32'(PAGE_SZ);
      return r;
    endfunction

    function void free_run(logic [31:0] addr);
      logic [31:0] rel;
      logic [31:0] want;
      int          idx;
      if (addr < region_base || addr >= region_limit) return;
      rel = addr - region_base;
      if (rel / 32'(PAGE_SZ) >= 32'(PAGES)) return;
      idx = int'(rel / 32'(PAGE_SZ));
      if (page_map[idx] == 0) return;
      want = page_map[idx];
      do begin
        page_map[idx] = '0;
        idx++;
        want = want + 32'(PAGE_SZ);
      end while (idx < PAGES && continues_run(page_map[idx], want));
    endfunction

    // only the next page is checked, however long the access
    function rsp_t translate(logic [31:0] addr, logic [12:0] len, logic exec);
      rsp_t        r;
      logic [31:0] rel;
      logic [31:0] off;
      logic [31:0] entry;
      int          idx;
      r.status         = 1'b1;
      r.result_address = '0;
      if (exec) return r;
      if (addr < region_base || addr >= region_limit) return r;
      rel = addr - region_base;
      if (rel / 32'(PAGE_SZ) >= 32'(PAGES)) return r;
      idx   = int'(rel / 32'(PAGE_SZ));
      off   = rel % 32'(PAGE_SZ);
      entry = page_map[idx];
      if (entry == 0) return r;
      if ({32'd0, off} + {51'd0, len} > 64'(PAGE_SZ) &&
          !continues_run(page_map[idx + 1], entry + 32'(PAGE_SZ))) return r;
      r.status         = 1'b0;
      r.result_address = entry + off;
      return r;
    endfunction

    function void note_request(req_t w);
      rsp_t r;
      r.status         = 1'b1;
      r.result_address = '0;
      case (w.kind)
        KIND_ALLOC:   r = allocate(w.request_bytes, w.backing_base);
        KIND_DEALLOC: begin
          free_run(w.address);
          r.status = 1'b0;
        end
        KIND_XLATE:   r = translate(w.address, w.access_length, w.is_exec);
        default: ;
      endcase
      pending_rsp.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("unexpected word: status %0d result_address %h", got.status, got.result_address);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.result_address !== want.result_address) begin
        $error("result_address: expected %h, got %h", want.result_address, got.result_address);
        errors++;
      end
    endfunction

    function int mapped_page();
      int k;
      int idx;
      for (k = 0; k < 24; k++) begin
        idx = $urandom_range(0, PAGES - 1);
        if (page_map[idx] != 0) return idx;
      end
      return -1;
    endfunction

    function int used_pages();
      int k;
      int cnt;
      cnt = 0;
      for (k = 0; k < PAGES; k++) if (page_map[k] != 0) cnt++;
      return cnt;
    endfunction
  endclass

  typedef page_map_scoreboard #(PAGE_COUNT, PAGE_BYTES) scoreboard_t;

  logic              clk_i;
  logic              rst_ni;
  logic              req_valid_i;
  logic              req_stall_o;
  req_t              req_i;
  logic              rsp_valid_o;
  logic              rsp_stall_i;
  rsp_t              rsp_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bit calm;
  scoreboard_t sb = new();

  page_run_allocator_with_translate_core #(
    .PAGE_COUNT(PAGE_COUNT),
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  initial begin : rsp_side
    int hold;
    hold = 0;
    rsp_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        rsp_stall_i = 1'b1;
        hold--;
      end else begin
        rsp_stall_i = 1'b0;
        if ($urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_response(rsp_o);
  end

  function automatic req_t mk_word(logic [1:0] kind, logic [31:0] bytes, logic [31:0] base,
                                   logic [31:0] addr, logic [12:0] len, logic exec);
    req_t w;
    w.kind          = kind;
    w.request_bytes = bytes;
    w.backing_base  = base;
    w.address       = addr;
    w.access_length = len;
    w.is_exec       = exec;
    return w;
  endfunction

  task automatic send_word(req_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      req_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_valid_i = 1'b1;
    req_i       = w;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(w);
  endtask

  // hold off until every expected word is back
  task automatic drain();
    @(negedge clk_i);
    req_valid_i = 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_AW'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_region(logic [31:0] base, logic [31:0] limit, logic [31:0] max_bytes);
    drain();
    apb_write(REG_REGION_BASE, base);
    apb_write(REG_REGION_LIMIT, limit);
    apb_write(REG_MAX_REQ, max_bytes);
  endtask

  function automatic logic [31:0] pick_address(bit near_end);
    int          pg;
    logic [31:0] off;
    pg  = sb.mapped_page();
    off = near_end ? 32'(PAGE_BYTES - $urandom_range(1, 16)) : $urandom_range(0, PAGE_BYTES - 1);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return sb.region_base + 32'($urandom_range(0, PAGE_COUNT + 8)) * PAGE_BYTES + off;
      default: begin
        if (pg < 0) pg = $urandom_range(0, PAGE_COUNT - 1);
        return sb.region_base + 32'(pg) * PAGE_BYTES + off;
      end
    endcase
  endfunction

  function automatic req_t next_word();
    req_t w;
    int   r;
    int   npg;
    int   pg;
    int   alloc_pct;
    w = mk_word(2'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom(),
                13'($urandom()), 1'($urandom()));
    alloc_pct = (sb.used_pages() > 180) ? 25 : 45;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      w.kind = KIND_NONE;
    end else if (r < 8) begin
      // noise: random fields as drawn
    end else if (r < 8 + alloc_pct) begin
      w.kind = KIND_ALLOC;
      npg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0: w.request_bytes = $urandom();
        1: w.request_bytes = sb.max_req + $urandom_range(0, 1);
        2: w.request_bytes = 32'(npg) * PAGE_BYTES;
        default: w.request_bytes = (npg == 0) ? 32'd0 :
                                   32'(npg) * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
      endcase
      pg = sb.mapped_page();
      r  = $urandom_range(0, 9);
      if (r == 0) begin
        w.backing_base = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
      end else if (r == 1) begin
        w.backing_base = 32'hFFFF_F000 - 32'($urandom_range(0, 8)) * PAGE_BYTES;
      end else if (r < 4 && pg >= 0) begin
        w.backing_base = sb.page_map[pg] + PAGE_BYTES;
      end else if (r == 4 && pg >= 0) begin
        w.backing_base = sb.page_map[pg] - 32'(npg) * PAGE_BYTES;
      end else begin
        w.backing_base = 32'h0100_0000 + 32'($urandom_range(0, 255)) * PAGE_BYTES;
      end
    end else if (r < 28 + alloc_pct) begin
      w.kind    = KIND_DEALLOC;
      w.address = pick_address(1'b0);
    end else begin
      w.kind    = KIND_XLATE;
      w.address = pick_address($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
        0: w.access_length = 13'($urandom_range(4097, 8191));
        1: w.access_length = 13'($urandom_range(0, 8));
        default: w.access_length = 13'($urandom_range(0, 4096));
      endcase
      w.is_exec = ($urandom_range(0, 9) == 0);
    end
    return w;
  endfunction

  task automatic run_phase(logic [31:0] base, logic [31:0] limit, logic [31:0] max_bytes,
                           int items, bit quiet);
    int k;
    set_region(base, limit, max_bytes);
    calm = quiet;
    for (k = 0; k < items; k++) begin
      if (k % 100 == 99) calm = quiet || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 299) == 0) drain();
      send_word(next_word());
    end
  endtask

  initial begin
    logic [31:0] rnd_base;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: empty table, single runs, contiguity and overflow corners
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1000, 4, 1'b0));
    send_word(mk_word(KIND_ALLOC,   0, 32'h0000_1000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   100, 0, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   32'h0010_0001, 32'h0000_5000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   32'h0010_0000, 32'h0000_5000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   255 * PAGE_BYTES, 32'h0100_0000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   PAGE_BYTES, 32'h0200_0000, 0, 0, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1000, 4096, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1FFF, 2, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_2000, 8191, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1000, 4, 1'b1));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h000F_FFFF, 0, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0010_0000, 1, 1'b0));
    send_word(mk_word(KIND_DEALLOC, 0, 0, 32'h0000_1800, 0, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1000, 4, 1'b0));
    send_word(mk_word(KIND_ALLOC,   2 * PAGE_BYTES, 32'hFFFF_F000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   PAGE_BYTES, 32'hFFFF_F000, 0, 0, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0000_1FFF, 8, 1'b0));
    send_word(mk_word(KIND_ALLOC,   PAGE_BYTES, 32'h0000_1000, 0, 0, 1'b0));
    send_word(mk_word(KIND_DEALLOC, 0, 0, 32'h0000_1000, 0, 1'b0));
    send_word(mk_word(KIND_DEALLOC, 0, 0, 32'hFFFF_FFFF, 0, 1'b0));
    send_word(mk_word(KIND_NONE, $urandom(), $urandom(), $urandom(), 13'($urandom()), 1'b1));

    // region larger than the table
    set_region(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(mk_word(KIND_XLATE,   0, 0, 32'h0030_0000, 4, 1'b0));
    send_word(mk_word(KIND_DEALLOC, 0, 0, 32'h0030_0000, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   32'hFFFF_FFFF, 32'h0000_1000, 0, 0, 1'b0));

    // region at the top of the address space: returned addresses wrap
    set_region(32'hFFFF_E000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(mk_word(KIND_ALLOC,   PAGE_BYTES, 32'h0300_0000, 0, 0, 1'b0));
    send_word(mk_word(KIND_ALLOC,   PAGE_BYTES, 32'h0500_0000, 0, 0, 1'b0));
    send_word(mk_word(KIND_XLATE,   0, 0, 32'hFFFF_F010, 4, 1'b0));

    run_phase(RST_REGION_BASE, RST_REGION_LIMIT, RST_MAX_REQ, 300, 1'b0);
    run_phase(32'h4000_0000, 32'h4000_0000 + 200 * PAGE_BYTES, 32'h0001_0000, 300, 1'b1);
    run_phase(32'h7FFF_F800, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 300, 1'b0);
    run_phase(32'hFFF8_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 250, 1'b0);
    run_phase(32'h0, 32'h0, 32'h0, 60, 1'b0);
    run_phase(32'h1234_5000, 32'h0000_1000, 32'h0000_8000, 60, 1'b1);
    rnd_base = $urandom();
    run_phase(rnd_base, rnd_base + 32'($urandom_range(1, 300)) * PAGE_BYTES,
              $urandom_range(0, 16 * PAGE_BYTES), 300, 1'b0);
    run_phase(RST_REGION_BASE, RST_REGION_LIMIT, RST_MAX_REQ, 280, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
